// ===== design/trst_pkg.sv =====
// ----------------------------------------------------------------------------
// trst_pkg
// Shared types, codes and the sequencer's control store for the tile
// residency slot table.
// ----------------------------------------------------------------------------
package trst_pkg;

    localparam int SLOTS      = 64;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int COORD_W    = 15;
    localparam int PC_W       = 4;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_WORLD_X = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_WORLD_Z = 1'b1;

    typedef enum logic [2:0] {
        CMD_REQUEST = 3'd0,
        CMD_MARK    = 3'd1,
        CMD_SCAN    = 3'd2,
        CMD_EVICT   = 3'd3,
        CMD_CLEAR   = 3'd4
    } trst_cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OUTSIDE    = 3'd1,
        ST_FULL       = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_NONE_STALE = 3'd4
    } trst_status_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_READ,
        OP_SRCH,
        OP_SCAN,
        OP_EVICT,
        OP_FIN_SRCH,
        OP_FIN_SCAN,
        OP_FIN_CNT
    } trst_op_t;

    typedef enum logic [2:0] {
        CND_NEXT,
        CND_GOTO,
        CND_DISPATCH,
        CND_BAD,
        CND_MORE
    } trst_cond_t;

    typedef logic [PC_W-1:0] trst_pc_t;

    typedef struct packed {
        trst_op_t   op;
        trst_cond_t cond;
        trst_pc_t   target;
    } trst_ctrl_t;

    typedef struct packed {
        logic stall;
        logic bad;
        logic more;
    } trst_stat_t;

    localparam trst_pc_t PC_IDLE      = 4'd0;
    localparam trst_pc_t PC_SRCH_INIT = 4'd1;
    localparam trst_pc_t PC_SRCH_READ = 4'd2;
    localparam trst_pc_t PC_SRCH_EVAL = 4'd3;
    localparam trst_pc_t PC_SRCH_FIN  = 4'd4;
    localparam trst_pc_t PC_SCAN_INIT = 4'd5;
    localparam trst_pc_t PC_SCAN_READ = 4'd6;
    localparam trst_pc_t PC_SCAN_EVAL = 4'd7;
    localparam trst_pc_t PC_SCAN_FIN  = 4'd8;
    localparam trst_pc_t PC_CNT_INIT  = 4'd9;
    localparam trst_pc_t PC_CNT_READ  = 4'd10;
    localparam trst_pc_t PC_CNT_EVAL  = 4'd11;
    localparam trst_pc_t PC_CNT_FIN   = 4'd12;

    // control store: one word per step
    function automatic trst_ctrl_t trst_rom(input trst_pc_t pc);
        trst_ctrl_t w;
        case (pc)
            PC_IDLE:      w = '{op: OP_NOP,      cond: CND_DISPATCH, target: PC_IDLE};
            PC_SRCH_INIT: w = '{op: OP_INIT,     cond: CND_BAD,      target: PC_SRCH_FIN};
            PC_SRCH_READ: w = '{op: OP_READ,     cond: CND_NEXT,     target: PC_IDLE};
            PC_SRCH_EVAL: w = '{op: OP_SRCH,     cond: CND_MORE,     target: PC_SRCH_READ};
            PC_SRCH_FIN:  w = '{op: OP_FIN_SRCH, cond: CND_GOTO,     target: PC_IDLE};
            PC_SCAN_INIT: w = '{op: OP_INIT,     cond: CND_NEXT,     target: PC_IDLE};
            PC_SCAN_READ: w = '{op: OP_READ,     cond: CND_NEXT,     target: PC_IDLE};
            PC_SCAN_EVAL: w = '{op: OP_SCAN,     cond: CND_MORE,     target: PC_SCAN_READ};
            PC_SCAN_FIN:  w = '{op: OP_FIN_SCAN, cond: CND_GOTO,     target: PC_IDLE};
            PC_CNT_INIT:  w = '{op: OP_INIT,     cond: CND_NEXT,     target: PC_IDLE};
            PC_CNT_READ:  w = '{op: OP_READ,     cond: CND_NEXT,     target: PC_IDLE};
            PC_CNT_EVAL:  w = '{op: OP_EVICT,    cond: CND_MORE,     target: PC_CNT_READ};
            PC_CNT_FIN:   w = '{op: OP_FIN_CNT,  cond: CND_GOTO,     target: PC_IDLE};
            default:      w = '{op: OP_NOP,      cond: CND_GOTO,     target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/trst_ram.sv =====
// ----------------------------------------------------------------------------
// trst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/trst_seq.sv =====
// ----------------------------------------------------------------------------
// trst_seq
// Step counter and control store: fetches one control word per step and
// resolves jumps from datapath status.
// ----------------------------------------------------------------------------
module trst_seq
    import trst_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  trst_cmd_t  s_cmd,
    input  trst_stat_t stat,
    output trst_ctrl_t ctrl,
    output logic       s_tready
);

    trst_pc_t pc_reg;
    trst_pc_t pc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    always_comb begin
        ctrl     = trst_rom(pc_reg);
        s_tready = (ctrl.cond == CND_DISPATCH);
        pc_next  = pc_reg;
        // hold the step while the datapath waits on the result register
        if (!stat.stall) begin
            case (ctrl.cond)
                CND_NEXT: pc_next = trst_pc_t'(pc_reg + 1'b1);
                CND_GOTO: pc_next = ctrl.target;
                CND_DISPATCH: begin
                    if (s_tvalid) begin
                        case (s_cmd)
                            CMD_REQUEST, CMD_MARK: pc_next = PC_SRCH_INIT;
                            CMD_SCAN:              pc_next = PC_SCAN_INIT;
                            CMD_EVICT, CMD_CLEAR:  pc_next = PC_CNT_INIT;
                            default:               pc_next = PC_IDLE;
                        endcase
                    end
                end
                CND_BAD:  pc_next = stat.bad ? ctrl.target : trst_pc_t'(pc_reg + 1'b1);
                CND_MORE: pc_next = stat.more ? ctrl.target : trst_pc_t'(pc_reg + 1'b1);
                default:  pc_next = PC_IDLE;
            endcase
        end
    end

endmodule

// ===== design/tile_residency_slot_table.sv =====
// ----------------------------------------------------------------------------
// tile_residency_slot_table
// Slot table of resident tiles: request, mark stale, scan stale, evict
// outside a window and clear, run by a microcoded sequencer over the slots.
// ----------------------------------------------------------------------------
// Sweep: each command sweeps all slots, reading memory and then evaluating
//   each slot in turn; a request outside the world and a mark with a
//   negative tile skip the sweep and go straight to their result step.
// Flow: one request at a time; the next is accepted once the sequencer is
//   back in idle after presenting the result; result steps hold while the
//   output is stalled, and scan also holds its sweep while a result waits
//   at the output.
// Reset: active and stale flags clear; the coordinate memory is not
//   cleared, it is read only for active slots. World size resets to 16.
// ----------------------------------------------------------------------------
module tile_residency_slot_table
    import trst_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COORD_W-1:0]    cfg_wdata,
    // requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,  // tile_x[15:0] tile_z[31:16] force_req[32] radius[47:33]
    input  logic [2:0]            s_tuser,  // command
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,  // slot[5:0] rebuild[6] out_tile_x[21:7]
                                            // out_tile_z[36:22] removed_count[43:37]
                                            // active_count[50:44] zero[55:51]
    output logic [2:0]            m_tuser,  // status
    output logic                  m_tlast   // last
);

    trst_ctrl_t ctrl;
    trst_stat_t stat;
    logic       accept;

    logic [COORD_W-1:0] wx_reg, wz_reg;

    trst_cmd_t          cmd_reg;
    logic signed [15:0] x_reg, z_reg;
    logic               force_reg;
    logic [14:0]        radius_reg;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic               bad_reg, bad_next;
    logic signed [17:0] lo_x_reg, lo_x_next, hi_x_reg, hi_x_next;
    logic signed [17:0] lo_z_reg, lo_z_next, hi_z_reg, hi_z_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [COORD_W-1:0] pend_x_reg, pend_x_next, pend_z_reg, pend_z_next;
    logic               pend_ok_reg, pend_ok_next;
    logic [CNT_W-1:0]   rem_reg, rem_next, act_reg, act_next;
    logic [SLOTS-1:0]   active_reg, active_next, stale_reg, stale_next;

    logic               out_valid_reg, out_valid_next;
    logic [5:0]         out_slot_reg, out_slot_next;
    trst_status_t       out_status_reg, out_status_next;
    logic               out_rebuild_reg, out_rebuild_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next, out_z_reg, out_z_next;
    logic [6:0]         out_rem_reg, out_rem_next, out_act_reg, out_act_next;
    logic               out_last_reg, out_last_next;

    logic                 ram_we;
    logic [2*COORD_W-1:0] ram_wdata, ram_rdata;
    logic [COORD_W-1:0]   rd_x, rd_z;

    logic               out_free, emit, stall, bad_now, in_world_in;
    logic               cur_act, cur_stale, rd_match, rd_ok, rd_out;
    logic signed [17:0] rd_sx, rd_sz, xs, zs, rs;
    logic               req_ok_emit, clear_done;

    assign accept = s_tvalid && s_tready;

    trst_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (trst_cmd_t'(s_tuser)),
        .stat     (stat),
        .ctrl     (ctrl),
        .s_tready (s_tready)
    );

    // coordinate store: {z, x} per slot
    trst_ram #(
        .WIDTH (2*COORD_W),
        .DEPTH (SLOTS)
    ) u_coord_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_x      = ram_rdata[COORD_W-1:0];
    assign rd_z      = ram_rdata[2*COORD_W-1:COORD_W];
    assign ram_wdata = {z_reg[COORD_W-1:0], x_reg[COORD_W-1:0]};

    assign stat.stall = stall;
    assign stat.bad   = bad_now;
    assign stat.more  = (idx_reg != IDX_W'(SLOTS - 1));

    always_comb begin
        out_free    = !out_valid_reg || m_tready;
        in_world_in = !x_reg[15] && !z_reg[15]
                   && (x_reg[COORD_W-1:0] < wx_reg) && (z_reg[COORD_W-1:0] < wz_reg);
        cur_act   = active_reg[idx_reg];
        cur_stale = stale_reg[idx_reg];
        rd_match  = (rd_x == x_reg[COORD_W-1:0]) && (rd_z == z_reg[COORD_W-1:0]);
        rd_ok     = (rd_x < wx_reg) && (rd_z < wz_reg);
        rd_sx     = signed'({3'b000, rd_x});
        rd_sz     = signed'({3'b000, rd_z});
        rd_out    = (rd_sx > hi_x_reg) || (rd_sx < lo_x_reg)
                 || (rd_sz > hi_z_reg) || (rd_sz < lo_z_reg);
        xs = 18'(x_reg);
        zs = 18'(z_reg);
        rs = signed'({3'b000, radius_reg});

        case (cmd_reg)
            CMD_REQUEST: bad_now = !in_world_in;
            CMD_MARK:    bad_now = x_reg[15] || z_reg[15];
            default:     bad_now = 1'b0;
        endcase

        idx_next      = idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        bad_next      = bad_reg;
        lo_x_next     = lo_x_reg;
        hi_x_next     = hi_x_reg;
        lo_z_next     = lo_z_reg;
        hi_z_next     = hi_z_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        pend_x_next   = pend_x_reg;
        pend_z_next   = pend_z_reg;
        pend_ok_next  = pend_ok_reg;
        rem_next      = rem_reg;
        act_next      = act_reg;
        active_next   = active_reg;
        stale_next    = stale_reg;
        ram_we        = 1'b0;
        stall         = 1'b0;
        req_ok_emit   = 1'b0;
        clear_done    = 1'b0;

        emit             = 1'b0;
        out_slot_next    = '0;
        out_status_next  = ST_OK;
        out_rebuild_next = 1'b0;
        out_x_next       = '0;
        out_z_next       = '0;
        out_rem_next     = '0;
        out_act_next     = '0;
        out_last_next    = 1'b1;

        case (ctrl.op)
            OP_INIT: begin
                idx_next  = '0;
                hit_next  = 1'b0;
                free_next = 1'b0;
                pend_next = 1'b0;
                rem_next  = '0;
                act_next  = '0;
                bad_next  = bad_now;
                lo_x_next = xs - rs;
                hi_x_next = xs + rs;
                lo_z_next = zs - rs;
                hi_z_next = zs + rs;
            end
            OP_SRCH: begin
                // keep the first match and the first free slot
                if (cur_act && rd_match && !hit_reg) begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                end
                if (!cur_act && !free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                idx_next = IDX_W'(idx_reg + 1'b1);
            end
            OP_SCAN: begin
                if (cur_act && cur_stale) begin
                    if (pend_reg && !out_free) begin
                        stall = 1'b1;
                    end else begin
                        // release the held result; this one may turn out to be the last
                        if (pend_reg) begin
                            emit             = 1'b1;
                            out_slot_next    = 6'(pend_idx_reg);
                            out_status_next  = pend_ok_reg ? ST_OK : ST_OUTSIDE;
                            out_rebuild_next = pend_ok_reg;
                            out_x_next       = pend_x_reg;
                            out_z_next       = pend_z_reg;
                            out_last_next    = 1'b0;
                        end
                        pend_next     = 1'b1;
                        pend_idx_next = idx_reg;
                        pend_x_next   = rd_x;
                        pend_z_next   = rd_z;
                        pend_ok_next  = rd_ok;
                        if (rd_ok) begin
                            stale_next[idx_reg] = 1'b0;
                        end
                    end
                end
                if (!stall) begin
                    idx_next = IDX_W'(idx_reg + 1'b1);
                end
            end
            OP_EVICT: begin
                if (cur_act) begin
                    if (cmd_reg == CMD_CLEAR || rd_out) begin
                        active_next[idx_reg] = 1'b0;
                        stale_next[idx_reg]  = 1'b0;
                        rem_next             = CNT_W'(rem_reg + 1'b1);
                    end else begin
                        act_next = CNT_W'(act_reg + 1'b1);
                    end
                end
                idx_next = IDX_W'(idx_reg + 1'b1);
            end
            OP_FIN_SRCH: begin
                if (!out_free) begin
                    stall = 1'b1;
                end else begin
                    emit = 1'b1;
                    if (cmd_reg == CMD_REQUEST) begin
                        if (bad_reg) begin
                            out_status_next = ST_OUTSIDE;
                        end else if (hit_reg || free_reg) begin
                            req_ok_emit = 1'b1;
                            out_x_next  = x_reg[COORD_W-1:0];
                            out_z_next  = z_reg[COORD_W-1:0];
                            if (hit_reg) begin
                                out_slot_next    = 6'(hit_idx_reg);
                                out_rebuild_next = stale_reg[hit_idx_reg] || force_reg;
                                active_next[hit_idx_reg] = 1'b1;
                                stale_next[hit_idx_reg]  = 1'b0;
                            end else begin
                                ram_we           = 1'b1;
                                out_slot_next    = 6'(free_idx_reg);
                                out_rebuild_next = 1'b1;
                                active_next[free_idx_reg] = 1'b1;
                                stale_next[free_idx_reg]  = 1'b0;
                            end
                        end else begin
                            out_status_next = ST_FULL;
                        end
                    end else begin
                        if (bad_reg || !hit_reg) begin
                            out_status_next = ST_NOT_FOUND;
                        end else begin
                            stale_next[hit_idx_reg] = 1'b1;
                            out_slot_next = 6'(hit_idx_reg);
                            out_x_next    = x_reg[COORD_W-1:0];
                            out_z_next    = z_reg[COORD_W-1:0];
                        end
                    end
                end
            end
            OP_FIN_SCAN: begin
                if (!out_free) begin
                    stall = 1'b1;
                end else begin
                    emit = 1'b1;
                    if (pend_reg) begin
                        out_slot_next    = 6'(pend_idx_reg);
                        out_status_next  = pend_ok_reg ? ST_OK : ST_OUTSIDE;
                        out_rebuild_next = pend_ok_reg;
                        out_x_next       = pend_x_reg;
                        out_z_next       = pend_z_reg;
                    end else begin
                        out_status_next = ST_NONE_STALE;
                    end
                end
            end
            OP_FIN_CNT: begin
                if (!out_free) begin
                    stall = 1'b1;
                end else begin
                    emit         = 1'b1;
                    clear_done   = (cmd_reg == CMD_CLEAR);
                    out_rem_next = 7'(rem_reg);
                    out_act_next = 7'(act_reg);
                end
            end
            default: begin
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wx_reg        <= COORD_W'(16);
            wz_reg        <= COORD_W'(16);
            active_reg    <= '0;
            stale_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_WORLD_X: wx_reg <= cfg_wdata;
                    REG_WORLD_Z: wz_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            active_reg    <= active_next;
            stale_reg     <= stale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= trst_cmd_t'(s_tuser);
            x_reg      <= signed'(s_tdata[15:0]);
            z_reg      <= signed'(s_tdata[31:16]);
            force_reg  <= s_tdata[32];
            radius_reg <= s_tdata[47:33];
        end
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        bad_reg      <= bad_next;
        lo_x_reg     <= lo_x_next;
        hi_x_reg     <= hi_x_next;
        lo_z_reg     <= lo_z_next;
        hi_z_reg     <= hi_z_next;
        pend_reg     <= pend_next;
        pend_idx_reg <= pend_idx_next;
        pend_x_reg   <= pend_x_next;
        pend_z_reg   <= pend_z_next;
        pend_ok_reg  <= pend_ok_next;
        rem_reg      <= rem_next;
        act_reg      <= act_next;
        if (emit) begin
            out_slot_reg    <= out_slot_next;
            out_status_reg  <= out_status_next;
            out_rebuild_reg <= out_rebuild_next;
            out_x_reg       <= out_x_next;
            out_z_reg       <= out_z_next;
            out_rem_reg     <= out_rem_next;
            out_act_reg     <= out_act_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b00000, out_act_reg, out_rem_reg, out_z_reg, out_x_reg,
                       out_rebuild_reg, out_slot_reg};

    // a slot is only stale while it is resident
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stale_reg & ~active_reg) == '0)
        else $error("stale flag set on an inactive slot");

    // a granted request leaves its slot resident and fresh
    assert property (@(posedge aclk) disable iff (!aresetn)
        req_ok_emit |=> active_reg[IDX_W'(out_slot_reg)] && !stale_reg[IDX_W'(out_slot_reg)])
        else $error("granted slot not resident after request");

    // clear empties the whole table by the time its result goes out
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear_done |=> active_reg == '0)
        else $error("active slots remain after clear");

    // no new request while a sweep is stalled on the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        stall |-> !s_tready)
        else $error("request accepted during a stalled sweep");

endmodule
